>>> hdl/ckc_pkg.sv
`default_nettype none

package ckc_pkg;

  localparam int KEY_BYTES_DEFAULT = 32;
  localparam int BUF_BYTES = 64;
  localparam int POS_W = 7;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam logic [7:0] DEFAULT_ROUNDS = 8'd20;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_1 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_2 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE = 4'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       round;
    logic       diag;
    logic [1:0] step;
    logic       hfinish;
    logic       init;
    logic       feed;
    logic       consume;
  } ckc_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       xmode;
    logic       cfg_hit;
    logic [7:0] rounds;
  } ckc_status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

endpackage

`default_nettype wire

>>> hdl/ckc_ctrl.sv
`default_nettype none

module ckc_ctrl
  import ckc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ckc_status_t status,
  input  wire logic        in_valid,
  input  wire logic        out_ready,
  output ckc_cmd_t         cmd,
  output logic             in_ready,
  output logic             out_valid
);

  typedef enum logic [6:0] {
    ST_LOAD   = 7'b0000001,
    ST_HROUND = 7'b0000010,
    ST_HFIN   = 7'b0000100,
    ST_INIT   = 7'b0001000,
    ST_ROUND  = 7'b0010000,
    ST_FEED   = 7'b0100000,
    ST_READY  = 7'b1000000
  } ckc_state_t;

  ckc_state_t state, state_next;
  logic [7:0] round_idx, round_idx_next;
  logic [1:0] step, step_next;
  logic       out_valid_next;
  logic       in_rounds;
  logic       last_step;
  logic       consume;

  assign in_rounds = (state == ST_HROUND) || (state == ST_ROUND);
  assign last_step = (step == 2'd3) && (round_idx == status.rounds - 8'd1);
  assign in_ready  = (state == ST_READY) && !status.empty && (!out_valid || out_ready);
  assign consume   = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.load    = (state == ST_LOAD);
    cmd.round   = in_rounds;
    cmd.diag    = round_idx[0];
    cmd.step    = step;
    cmd.hfinish = (state == ST_HFIN);
    cmd.init    = (state == ST_INIT);
    cmd.feed    = (state == ST_FEED);
    cmd.consume = consume;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   state_next = status.xmode ? ST_HROUND : ST_ROUND;
      ST_HROUND: if (last_step) state_next = ST_HFIN;
      ST_HFIN:   state_next = ST_INIT;
      ST_INIT:   state_next = ST_ROUND;
      ST_ROUND:  if (last_step) state_next = ST_FEED;
      ST_FEED:   state_next = ST_READY;
      ST_READY:  if (status.empty) state_next = ST_INIT;
      default:   state_next = ST_LOAD;
    endcase
    if (status.cfg_hit) begin
      state_next = ST_LOAD;
    end
  end

  always_comb begin
    round_idx_next = '0;
    step_next      = '0;
    if (in_rounds && !last_step) begin
      step_next      = step + 2'd1;
      round_idx_next = (step == 2'd3) ? round_idx + 8'd1 : round_idx;
    end
    if (status.cfg_hit) begin
      round_idx_next = '0;
      step_next      = '0;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (consume) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      round_idx <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      round_idx <= round_idx_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ckc_datapath.sv
`default_nettype none

module ckc_datapath
  import ckc_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_word_t              in_data,
  input  wire ckc_cmd_t              cmd,
  output ckc_status_t                status,
  output out_word_t                  out_data
);

  localparam int KB_TENS = (KEY_BYTES / 10) % 10;
  localparam int KB_UNITS = KEY_BYTES % 10;
  localparam logic [31:0] CONST_0 = 32'h61707865;
  localparam logic [31:0] CONST_1 = {8'(8'h30 + KB_TENS), 24'h20646e};
  localparam logic [31:0] CONST_2 = {24'h79622d, 8'(8'h30 + KB_UNITS)};
  localparam logic [31:0] CONST_3 = 32'h6b206574;

  logic [63:0] key_0, key_1, key_2, key_3;
  logic [63:0] nonce_0, nonce_1, nonce_2;
  logic [8:0]  round_mode;
  logic [POS_W-1:0] pos;

  logic [15:0][31:0] cs;
  logic [15:0][31:0] w;
  logic [15:0][31:0] w_rnd;
  logic [15:0][31:0] init_vec;
  logic [255:0] key_all;
  logic [255:0] key_rep;
  logic [7:0]   ks_byte;
  logic [63:0]  counter_inc;

  assign key_all = {key_3, key_2, key_1, key_0};

  for (genvar k = 0; k < 32; k++) begin : g_key
    localparam int J = k % KEY_BYTES;
    assign key_rep[8*k +: 8] = key_all[8*J +: 8];
  end

  always_comb begin
    init_vec[0] = CONST_0;
    init_vec[1] = CONST_1;
    init_vec[2] = CONST_2;
    init_vec[3] = CONST_3;
    for (int i = 0; i < 8; i++) begin
      init_vec[4+i] = key_rep[32*i +: 32];
    end
    if (round_mode[8]) begin
      init_vec[12] = nonce_0[31:0];
      init_vec[13] = nonce_0[63:32];
      init_vec[14] = nonce_1[31:0];
      init_vec[15] = nonce_1[63:32];
    end else begin
      init_vec[12] = '0;
      init_vec[13] = '0;
      init_vec[14] = nonce_0[31:0];
      init_vec[15] = nonce_0[63:32];
    end
  end

  // One quarter-round step on all four lanes; the diagonal round shifts rows one to three.
  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] sum;
    w_rnd = w;
    for (int i = 0; i < 4; i++) begin
      ia = {2'd0, 2'(i)};
      ib = {2'd1, 2'(i) + {1'b0, cmd.diag}};
      ic = {2'd2, 2'(i) + {cmd.diag, 1'b0}};
      id = {2'd3, 2'(i) + {cmd.diag, cmd.diag}};
      case (cmd.step)
        2'd0: begin
          sum       = w[ia] + w[ib];
          w_rnd[ia] = sum;
          w_rnd[id] = rotl32(w[id] ^ sum, 16);
        end
        2'd1: begin
          sum       = w[ic] + w[id];
          w_rnd[ic] = sum;
          w_rnd[ib] = rotl32(w[ib] ^ sum, 12);
        end
        2'd2: begin
          sum       = w[ia] + w[ib];
          w_rnd[ia] = sum;
          w_rnd[id] = rotl32(w[id] ^ sum, 8);
        end
        default: begin
          sum       = w[ic] + w[id];
          w_rnd[ic] = sum;
          w_rnd[ib] = rotl32(w[ib] ^ sum, 7);
        end
      endcase
    end
  end

  assign ks_byte     = w[pos[5:2]][8*pos[1:0] +: 8];
  assign counter_inc = {cs[13], cs[12]} + 64'd1;

  always_comb begin
    status         = '0;
    status.empty   = pos[POS_W-1];
    status.xmode   = round_mode[8];
    status.cfg_hit = cfg_we && (cfg_index <= REG_ROUND_MODE);
    status.rounds  = (round_mode[7:0] == 8'd0) ? DEFAULT_ROUNDS : round_mode[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_0      <= '0;
      key_1      <= '0;
      key_2      <= '0;
      key_3      <= '0;
      nonce_0    <= '0;
      nonce_1    <= '0;
      nonce_2    <= '0;
      round_mode <= {1'b0, DEFAULT_ROUNDS};
      pos        <= POS_W'(BUF_BYTES);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_0:      key_0 <= cfg_data;
          REG_KEY_1:      key_1 <= cfg_data;
          REG_KEY_2:      key_2 <= cfg_data;
          REG_KEY_3:      key_3 <= cfg_data;
          REG_NONCE_0:    nonce_0 <= cfg_data;
          REG_NONCE_1:    nonce_1 <= cfg_data;
          REG_NONCE_2:    nonce_2 <= cfg_data;
          REG_ROUND_MODE: round_mode <= cfg_data[8:0];
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        pos <= POS_W'(BUF_BYTES);
      end else if (cmd.feed) begin
        pos <= '0;
      end else if (cmd.consume) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w <= init_vec;
    end else if (cmd.round) begin
      w <= w_rnd;
    end else if (cmd.init) begin
      w <= cs;
    end else if (cmd.feed) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= w[i] + cs[i];
      end
    end

    if (cmd.load) begin
      cs <= init_vec;
    end else if (cmd.hfinish) begin
      for (int i = 0; i < 4; i++) begin
        cs[4+i] <= w[i];
        cs[8+i] <= w[12+i];
      end
      cs[12] <= '0;
      cs[13] <= '0;
      cs[14] <= nonce_2[31:0];
      cs[15] <= nonce_2[63:32];
    end else if (cmd.feed) begin
      cs[12] <= counter_inc[31:0];
      cs[13] <= counter_inc[63:32];
    end

    if (cmd.consume) begin
      out_data.out_byte <= in_data.data_byte ^ ks_byte;
      out_data.last_out <= in_data.end_of_message;
    end
  end

endmodule

`default_nettype wire

>>> hdl/chacha_keystream_cipher.sv
// An accepted word's result is registered; out_data and out_valid load on acceptance.
// The block takes one word per cycle while keystream remains and out_ready does not
// stall output; every 64 words it pauses to refill, one quarter-round step per cycle.
// Setup after reset or a register write is a load, plus rounds and finish in XChaCha mode.
// Reset restores the register defaults and runs setup; the first refill follows at once.
`default_nettype none

module chacha_keystream_cipher
  import ckc_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data
);

  ckc_cmd_t    cmd;
  ckc_status_t status;

  ckc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  ckc_datapath #(
    .KEY_BYTES (KEY_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("word accepted while an undelivered result is held");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted word produced no result");

  a_ready_needs_keystream: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.empty)
    else $error("word accepted with an empty keystream buffer");

  a_feed_fills: assert property (@(posedge clk) disable iff (rst)
    (cmd.feed && !status.cfg_hit) |=> !status.empty)
    else $error("refill did not leave keystream available");

endmodule

`default_nettype wire
